@@ rtl/core/msaru_pkg.sv @@
// ----------------------------------------------------------------------------
// msaru_pkg
// Shared types and codes of the lane-masked SIMD ALU and register file.
// ----------------------------------------------------------------------------
package msaru_pkg;

  // Item kinds
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Lane operation codes
  localparam logic [3:0] ALU_NOP   = 4'd0;
  localparam logic [3:0] ALU_ADD   = 4'd1;
  localparam logic [3:0] ALU_SUB   = 4'd2;
  localparam logic [3:0] ALU_MUL   = 4'd3;
  localparam logic [3:0] ALU_MAX   = 4'd4;
  localparam logic [3:0] ALU_MIN   = 4'd5;
  localparam logic [3:0] ALU_XOR   = 4'd6;
  localparam logic [3:0] ALU_AND   = 4'd7;
  localparam logic [3:0] ALU_SHL   = 4'd8;
  localparam logic [3:0] ALU_CMPLT = 4'd9;
  localparam logic [3:0] ALU_ABSD  = 4'd10;
  localparam logic [3:0] ALU_CLAMP = 4'd11;
  localparam logic [3:0] ALU_LIMIT = 4'd12;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_RDD,
    ST_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  alu_op;
    logic [1:0]  warp;
    logic [3:0]  dst_reg;
    logic [3:0]  src_a_reg;
    logic [3:0]  src_b_reg;
    logic [7:0]  lane_en;
    logic [31:0] immediate;
    logic [2:0]  lane_sel;
    logic [31:0] write_value;
  } item_t;

  typedef struct packed {
    logic [31:0] lane_value;
    logic [2:0]  lane_index;
    logic        last;
    logic        error;
    logic [31:0] instruction_count;
    logic [31:0] active_lane_count;
    logic [31:0] masked_lane_count;
  } result_t;

  // One lane of the ALU
  function automatic logic [31:0] lane_alu(input logic [3:0] code,
                                           input logic [31:0] a,
                                           input logic [31:0] b,
                                           input logic [31:0] imm);
    logic        lt;
    logic [32:0] d;
    logic [32:0] m;
    logic [31:0] hi;
    lt = $signed(a) < $signed(b);
    d  = {a[31], a} - {b[31], b};
    m  = d[32] ? (33'd0 - d) : d;
    hi = imm[31] ? 32'd0 : imm;
    unique case (code)
      ALU_ADD:   lane_alu = a + b;
      ALU_SUB:   lane_alu = a - b;
      ALU_MUL:   lane_alu = a * b;
      ALU_MAX:   lane_alu = lt ? b : a;
      ALU_MIN:   lane_alu = ($signed(b) < $signed(a)) ? b : a;
      ALU_XOR:   lane_alu = a ^ b;
      ALU_AND:   lane_alu = a & b;
      ALU_SHL:   lane_alu = a << b[4:0];
      ALU_CMPLT: lane_alu = {31'd0, lt};
      ALU_ABSD:  lane_alu = (m > {1'b0, SAT_MAX}) ? SAT_MAX : m[31:0];
      ALU_CLAMP: lane_alu = a[31] ? 32'd0 : ((a > hi) ? hi : a);
      default:   lane_alu = a;
    endcase
  endfunction

endpackage

@@ rtl/core/msaru_if.sv @@
// ----------------------------------------------------------------------------
// msaru_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface msaru_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/masked_simd_alu_register_file.sv @@
// ----------------------------------------------------------------------------
// masked_simd_alu_register_file
// Per-warp vector register file with a lane-masked 32-bit SIMD ALU.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload   Transfer
// in       in   item_t    in.valid & in.ready
// out      out  result_t  out.valid & out.ready
//
// Register file: one memory, one row per (warp, register), LANES words wide,
// with a registered read. Execute: accept, then ST_RDA, ST_RDB, ST_RDD, ST_WB
// (read a, read b, compute and read destination, write back), then the result.
// Write-lane: accept, ST_RDD and ST_WB (read row, merge and write), result.
// Read: accept, ST_RDD, ST_WB, then a result per lane, at most eight. Other
// kinds go straight to ST_OUT. After reset a clearing pass zeroes every row;
// no item is taken meanwhile. A stalled output holds the block in ST_OUT.
// ----------------------------------------------------------------------------
module masked_simd_alu_register_file
  import msaru_pkg::*;
#(
  parameter int WARPS         = 4,
  parameter int REGS_PER_WARP = 16,
  parameter int LANES         = 8
) (
  input  logic           clk,
  input  logic           rst,
  msaru_if.sink          in,
  msaru_if.source        out
);

  localparam int ROWS  = WARPS * REGS_PER_WARP;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NOUT  = (LANES < 8) ? LANES : 8;
  localparam int VW    = LANES * 32;

  // Register file memory
  logic [VW-1:0] mem [ROWS];
  logic [VW-1:0] rd_data;
  logic [RW-1:0] rd_addr;
  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  state_t           state, state_next;
  item_t            item;
  logic [RW-1:0]    clr_cnt;
  logic [VW-1:0]    vec_a;
  logic [VW-1:0]    vec_res;
  logic [VW-1:0]    row_q;
  logic [VW-1:0]    merged;
  logic [2:0]       out_lane;
  logic             err;
  logic [31:0]      instr_cnt, act_cnt, msk_cnt;
  logic [31:0]      rd_val;
  logic             idx_ok;
  logic             src_ok;
  logic             exec_ok;
  logic             wr_ok;
  logic [LANES-1:0] en_lane;
  logic [31:0]      n_act;

  function automatic logic [RW-1:0] row_of(input logic [1:0] w, input logic [3:0] r);
    logic [31:0] x;
    x = 32'(w) * 32'(REGS_PER_WARP) + 32'(r);
    return x[RW-1:0];
  endfunction

  assign idx_ok = (32'(item.warp) < 32'(WARPS)) && (32'(item.dst_reg) < 32'(REGS_PER_WARP));
  assign src_ok = (32'(item.src_a_reg) < 32'(REGS_PER_WARP)) &&
                  (32'(item.src_b_reg) < 32'(REGS_PER_WARP));
  assign exec_ok = (item.op == OP_EXEC) && (item.alu_op < ALU_LIMIT) && idx_ok && src_ok;
  assign wr_ok   = (item.op == OP_WRITE) && idx_ok && (32'(item.lane_sel) < 32'(LANES));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == RW'(ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in.valid) begin
        unique case (in.data.op)
          OP_EXEC:           state_next = ST_RDA;
          OP_WRITE, OP_READ: state_next = ST_RDD;
          default:           state_next = ST_OUT;
        endcase
      end
      ST_RDA:   state_next = ST_RDB;
      ST_RDB:   state_next = ST_RDD;
      ST_RDD:   state_next = ST_WB;
      ST_WB:    state_next = ST_OUT;
      ST_OUT:   if (out.ready && out.data.last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory port control and handshakes
  always_comb begin
    unique case (state)
      ST_RDA:  rd_addr = row_of(item.warp, item.src_a_reg);
      ST_RDB:  rd_addr = row_of(item.warp, item.src_b_reg);
      default: rd_addr = row_of(item.warp, item.dst_reg);
    endcase
    wr_en   = 1'b0;
    wr_addr = row_of(item.warp, item.dst_reg);
    wr_data = merged;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (state == ST_WB) begin
      wr_en = (exec_ok && item.alu_op != ALU_NOP) || wr_ok;
    end
    in.ready  = (state == ST_IDLE);
    out.valid = (state == ST_OUT);
  end

  // Enabled lanes; lanes from eight upwards have no mask bit
  always_comb begin
    n_act = '0;
    for (int i = 0; i < LANES; i++) begin
      en_lane[i] = (i < 8) ? item.lane_en[i % 8] : 1'b0;
      n_act = n_act + 32'(en_lane[i]);
    end
  end

  // Merge into the old destination row, which sits in rd_data during ST_WB
  always_comb begin
    merged = rd_data;
    for (int i = 0; i < LANES; i++) begin
      if (item.op == OP_WRITE) begin
        if (32'(item.lane_sel) == 32'(i)) merged[i*32 +: 32] = item.write_value;
      end else if (en_lane[i]) begin
        merged[i*32 +: 32] = vec_res[i*32 +: 32];
      end
    end
  end

  // Stage registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      item      <= '0;
      instr_cnt <= '0;
      act_cnt   <= '0;
      msk_cnt   <= '0;
      out_lane  <= '0;
      err       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + RW'(1);
      if (in.valid && in.ready) begin
        item     <= in.data;
        out_lane <= '0;
        err      <= (in.data.op == OP_EXEC) && (in.data.alu_op >= ALU_LIMIT);
      end
      // source a arrives
      if (state == ST_RDB) vec_a <= rd_data;
      // source b arrives: compute every lane
      if (state == ST_RDD) begin
        for (int i = 0; i < LANES; i++)
          vec_res[i*32 +: 32] <= lane_alu(item.alu_op, vec_a[i*32 +: 32],
                                          rd_data[i*32 +: 32], item.immediate);
      end
      if (state == ST_WB) begin
        row_q <= rd_data;
        if (exec_ok) begin
          instr_cnt <= instr_cnt + 32'd1;
          if (item.alu_op != ALU_NOP) begin
            act_cnt <= act_cnt + n_act;
            msk_cnt <= msk_cnt + (32'(LANES) - n_act);
          end
        end
      end
      if (out.valid && out.ready) out_lane <= out_lane + 3'd1;
    end
  end

  // Lane picked for a read result
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < NOUT; i++)
      if (32'(out_lane) == 32'(i) && idx_ok) rd_val = row_q[i*32 +: 32];
  end

  always_comb begin
    out.data = '0;
    out.data.last  = (item.op == OP_READ) ? (32'(out_lane) == 32'(NOUT - 1)) : 1'b1;
    out.data.error = err;
    out.data.instruction_count = instr_cnt;
    out.data.active_lane_count = act_cnt;
    out.data.masked_lane_count = msk_cnt;
    if (item.op == OP_READ) begin
      out.data.lane_value = rd_val;
      out.data.lane_index = out_lane;
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in.ready) else $error("ready outside idle");
  a_clear_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out.valid) else $error("result during clear");
  a_err_exec: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.data.error) |-> (item.op == OP_EXEC)) else $error("bad error");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(out.data)))
    else $error("result changed while stalled");
`endif

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lane-masked SIMD ALU and register file. Items go
// in over a valid/ready channel, a local predictor keeps its own copy of the
// register file and counters, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import msaru_pkg::*;

  localparam int NW = 4;
  localparam int NR = 16;
  localparam int NL = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msaru_if #(.payload_t(item_t))   in_ch  ();
  msaru_if #(.payload_t(result_t)) out_ch ();

  masked_simd_alu_register_file #(
    .WARPS(NW), .REGS_PER_WARP(NR), .LANES(NL)
  ) uut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [31:0] vregs [NW][NR][NL];
  logic [31:0] insn_cnt, active_cnt, masked_cnt;
  result_t     expected_results [$];
  int          fail_count = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;

  function automatic logic [31:0] predict_lane(logic [3:0] code, logic [31:0] a,
                                               logic [31:0] b, logic [31:0] imm);
    logic signed [33:0] d;
    logic [31:0] hi;
    d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
    if (d < 0) d = -d;
    hi = imm[31] ? 32'd0 : imm;
    case (code)
      ALU_ADD:   return a + b;
      ALU_SUB:   return a - b;
      ALU_MUL:   return a * b;
      ALU_MAX:   return ($signed(a) < $signed(b)) ? b : a;
      ALU_MIN:   return ($signed(b) < $signed(a)) ? b : a;
      ALU_XOR:   return a ^ b;
      ALU_AND:   return a & b;
      ALU_SHL:   return a << b[4:0];
      ALU_CMPLT: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      ALU_ABSD:  return (d > 34'sh7FFFFFFF) ? SAT_MAX : d[31:0];
      ALU_CLAMP: return a[31] ? 32'd0 : ((a > hi) ? hi : a);
      default:   return a;
    endcase
  endfunction

  function automatic result_t mk_result(logic [31:0] v, logic [2:0] idx,
                                        logic lst, logic err);
    result_t r;
    r.lane_value = v; r.lane_index = idx; r.last = lst; r.error = err;
    r.instruction_count = insn_cnt;
    r.active_lane_count = active_cnt;
    r.masked_lane_count = masked_cnt;
    return r;
  endfunction

  // Random fill of every item field
  function automatic item_t rand_fill();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(item_t)-1:0];
  endfunction

  // Update the predictor and queue the results an item causes
  task automatic predict_item(item_t it);
    logic [31:0] a [NL];
    logic [31:0] b [NL];
    logic        err;
    err = 1'b0;
    case (it.op)
      OP_EXEC: begin
        if (it.alu_op >= ALU_LIMIT) begin
          err = 1'b1;
        end else begin
          if (it.alu_op != ALU_NOP) begin
            a = vregs[it.warp][it.src_a_reg];
            b = vregs[it.warp][it.src_b_reg];
            for (int l = 0; l < NL; l++) begin
              if (it.lane_en[l]) begin
                vregs[it.warp][it.dst_reg][l] =
                  predict_lane(it.alu_op, a[l], b[l], it.immediate);
                active_cnt++;
              end else begin
                masked_cnt++;
              end
            end
          end
          insn_cnt++;
        end
        expected_results.push_back(mk_result(32'd0, 3'd0, 1'b1, err));
      end
      OP_WRITE: begin
        vregs[it.warp][it.dst_reg][it.lane_sel] = it.write_value;
        expected_results.push_back(mk_result(32'd0, 3'd0, 1'b1, 1'b0));
      end
      OP_READ: begin
        for (int l = 0; l < NL; l++)
          expected_results.push_back(mk_result(vregs[it.warp][it.dst_reg][l],
                                               3'(l), l == NL - 1, 1'b0));
      end
      default: expected_results.push_back(mk_result(32'd0, 3'd0, 1'b1, 1'b0));
    endcase
  endtask

  // Drive one item; gaps at random
  task automatic send_item(item_t it);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 18) @(negedge clk);
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic item_t rand_item();
    item_t it;
    it = rand_fill();
    it.op = 2'($urandom_range(2));
    if ($urandom_range(9) == 0) it.op = 2'd3;
    if (it.op == OP_EXEC && $urandom_range(9) == 0) it.alu_op = 4'($urandom_range(15, 12));
    else if (it.op == OP_EXEC) it.alu_op = 4'($urandom_range(11));
    return it;
  endfunction

  function automatic item_t exec_item(logic [3:0] code, logic [3:0] d, logic [3:0] sa,
                                      logic [3:0] sb, logic [7:0] m, logic [31:0] imm);
    item_t it;
    it = rand_fill();
    it.op = OP_EXEC; it.alu_op = code; it.warp = 2'd1;
    it.dst_reg = d; it.src_a_reg = sa; it.src_b_reg = sb;
    it.lane_en = m; it.immediate = imm;
    return it;
  endfunction

  task automatic write_lane(logic [1:0] w, logic [3:0] r, logic [2:0] l, logic [31:0] v);
    item_t it;
    it = rand_fill();
    it.op = OP_WRITE; it.warp = w; it.dst_reg = r; it.lane_sel = l; it.write_value = v;
    send_item(it);
  endtask

  task automatic read_reg(logic [1:0] w, logic [3:0] r);
    item_t it;
    it = rand_fill();
    it.op = OP_READ; it.warp = w; it.dst_reg = r;
    send_item(it);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Loads of edge values, then every operation over them
  task automatic test_directed_ops();
    logic [31:0] edges [NL] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                                32'd1, 32'h8000_0001, 32'd33, 32'h1234_5678};
    for (int l = 0; l < NL; l++) begin
      write_lane(2'd1, 4'd0, 3'(l), edges[l]);
      write_lane(2'd1, 4'd1, 3'(l), edges[NL - 1 - l]);
    end
    for (int c = 0; c < 12; c++)
      send_item(exec_item(4'(c), 4'(c % 4 + 2), 4'd0, 4'd1, 8'hFF,
                          c[0] ? 32'h8000_0000 : 32'h7FFF_FFFE));
    send_item(exec_item(ALU_CLAMP, 4'd14, 4'd1, 4'd0, 8'hA5, 32'd5));
    send_item(exec_item(ALU_ADD, 4'd15, 4'd0, 4'd0, 8'h00, 32'd0));
    send_item(exec_item(4'd15, 4'd15, 4'd0, 4'd0, 8'hFF, 32'd0));
    read_reg(2'd1, 4'd14);
    read_reg(2'd1, 4'd15);
  endtask

  // Random traffic; mostly writes and executes on a small register window
  task automatic test_random_traffic();
    item_t it;
    for (int n = 0; n < 237; n++) begin
      if (n == 60) idle_on = 1'b0;
      if (n == 120) idle_on = 1'b1;
      if (n == 150) wait_drained();
      it = rand_item();
      if ($urandom_range(3) != 0) begin
        it.src_a_reg[3:2] = 2'b00;
        it.src_b_reg[3:2] = 2'b00;
        it.dst_reg[3:2]   = 2'b00;
      end
      send_item(it);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        result_t e, g;
        e = expected_results.pop_front();
        g = out_ch.data;
        if (g.lane_value !== e.lane_value) begin
          $error("lane_value exp %h got %h", e.lane_value, g.lane_value); fail_count++;
        end
        if (g.lane_index !== e.lane_index) begin
          $error("lane_index exp %0d got %0d", e.lane_index, g.lane_index); fail_count++;
        end
        if (g.last !== e.last) begin
          $error("last exp %b got %b", e.last, g.last); fail_count++;
        end
        if (g.error !== e.error) begin
          $error("error exp %b got %b", e.error, g.error); fail_count++;
        end
        if (g.instruction_count !== e.instruction_count) begin
          $error("instruction_count exp %0d got %0d", e.instruction_count,
                 g.instruction_count); fail_count++;
        end
        if (g.active_lane_count !== e.active_lane_count) begin
          $error("active_lane_count exp %0d got %0d", e.active_lane_count,
                 g.active_lane_count); fail_count++;
        end
        if (g.masked_lane_count !== e.masked_lane_count) begin
          $error("masked_lane_count exp %0d got %0d", e.masked_lane_count,
                 g.masked_lane_count); fail_count++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= !(idle_on && $urandom_range(99) < 18);
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    foreach (vregs[w, r, l]) vregs[w][r][l] = 32'd0;
    insn_cnt = 0; active_cnt = 0; masked_cnt = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_random_traffic();
    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/msaru_pkg.sv
rtl/core/msaru_if.sv
rtl/core/masked_simd_alu_register_file.sv
tb/sv/tb.sv
